// ===== rtl/bdc_pkg.sv =====
// Shared constants for the baud divisor calculator.
package bdc_pkg;

    // Default build parameters.
    localparam int unsigned DEF_INPUT_CLOCK_HZ = 52000000;
    localparam int unsigned DEF_OVERSAMPLE     = 16;
    localparam int unsigned DEF_DIVIDER_MAX    = 8191;

    // Fractional divider: numerator over 2**FRAC_SHIFT.
    localparam int unsigned FRAC_SHIFT = 9;
    localparam int unsigned FRAC_FIRST = 256;

    // Field widths of the words on the channels.
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned DIV_W    = 13;
    localparam int unsigned FRAC_W   = 10;
    localparam int unsigned ACTUAL_W = 22;

endpackage

// ===== rtl/bdc_if.sv =====
// Valid/ready channel interfaces for the request and result words.
interface bdc_in_if
    import bdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

interface bdc_out_if
    import bdc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DIV_W-1:0]    divider_value;
    logic [FRAC_W-1:0]   fraction_value;
    logic [ACTUAL_W-1:0] actual_rate;
    logic                rate_invalid;

    modport source (output valid, output divider_value, output fraction_value,
                    output actual_rate, output rate_invalid, input ready);
    modport sink   (input valid, input divider_value, input fraction_value,
                    input actual_rate, input rate_invalid, output ready);
endinterface

// ===== rtl/bdc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module bdc_div #(
    parameter int unsigned NUM_W = 31,
    parameter int unsigned DEN_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   s_trial;
    logic             s_ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        s_trial = {r_rem, r_quo[NUM_W-1]};
        s_ge    = (s_trial >= {1'b0, r_den});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_quo = {r_quo[NUM_W-2:0], s_ge};
            n_rem = s_ge ? DEN_W'(s_trial - {1'b0, r_den}) : s_trial[DEN_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/baud_divisor_calculator_top.sv =====
// Baud divisor calculator: a sequencer around one shared bit-serial divider.
// The shared divider yields one quotient bit per cycle and is used up to five
// times in a row for one request word. Before the last division the divider
// value is halved step by step until it is at or below DIVIDER_MAX. With the
// default 52 MHz clock and 16x oversampling the top rate INPUT_CLOCK_HZ /
// OVERSAMPLE is 22 bits wide. A zero rate or a rate at or above the top rate
// goes straight to the result without the divider. The block takes one word
// at a time and drops ready until its result word is taken.
module baud_divisor_calculator_top
    import bdc_pkg::*;
#(
    parameter int unsigned INPUT_CLOCK_HZ = DEF_INPUT_CLOCK_HZ,
    parameter int unsigned OVERSAMPLE     = DEF_OVERSAMPLE,
    parameter int unsigned DIVIDER_MAX    = DEF_DIVIDER_MAX
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bdc_in_if.sink  i_in,
    bdc_out_if.source o_out
);

    localparam int unsigned OS_EFF = (OVERSAMPLE == 0) ? 1 : OVERSAMPLE;
    localparam int unsigned TOP    = INPUT_CLOCK_HZ / OS_EFF;
    localparam int unsigned TOPW   = $clog2(TOP + 1);
    localparam int unsigned NUMW   = TOPW + FRAC_SHIFT;
    localparam int unsigned WGT_W  = FRAC_W - 1;
    localparam logic [NUMW-1:0] TOP_NUM = NUMW'(TOP);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_QDIV  = 10'b0000000010,
        S_GDIV  = 10'b0000000100,
        S_DDIV  = 10'b0000001000,
        S_FDIV  = 10'b0000010000,
        S_SHIFT = 10'b0000100000,
        S_RDIV  = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_SCALE = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [TOPW-1:0]     r_rate, n_rate;
    logic [TOPW-1:0]     r_good, n_good;
    logic [TOPW-1:0]     r_div, n_div;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [WGT_W-1:0]    r_weight, n_weight;
    logic                r_exact, n_exact;
    logic [TOPW-1:0]     r_act, n_act;
    logic [TOPW+FRAC_W-1:0] r_prod, n_prod;
    logic                r_inval, n_inval;

    logic                s_start;
    logic [NUMW-1:0]     s_num;
    logic [TOPW-1:0]     s_den;
    logic                s_done;
    logic [NUMW-1:0]     s_quo;
    logic [TOPW-1:0]     s_rem;
    logic [TOPW-1:0]     s_quo_lo;
    logic                s_div_big;

    assign s_quo_lo  = s_quo[TOPW-1:0];
    assign s_div_big = (32'(r_div) > 32'(DIVIDER_MAX));

    // Shared divider used for every quotient in the flow.
    bdc_div #(
        .NUM_W (NUMW),
        .DEN_W (TOPW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_num   (s_num),
        .i_den   (s_den),
        .o_done  (s_done),
        .o_quo   (s_quo),
        .o_rem   (s_rem)
    );

    // Sequencer: picks the next division and updates the working registers.
    always_comb begin
        n_state  = r_state;
        n_rate   = r_rate;
        n_good   = r_good;
        n_div    = r_div;
        n_frac   = r_frac;
        n_weight = r_weight;
        n_exact  = r_exact;
        n_act    = r_act;
        n_prod   = r_prod;
        n_inval  = r_inval;
        s_start  = 1'b0;
        s_num    = TOP_NUM;
        s_den    = s_quo_lo;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_div   = '0;
                    n_frac  = '0;
                    n_inval = 1'b0;
                    n_rate  = i_in.baud_rate[TOPW-1:0];
                    if (i_in.baud_rate == '0) begin
                        n_inval = 1'b1;
                        n_act   = '0;
                        n_state = S_OUT;
                    end else if (i_in.baud_rate >= RATE_W'(TOP)) begin
                        n_act   = TOPW'(TOP);
                        n_state = S_OUT;
                    end else begin
                        s_start = 1'b1;
                        s_den   = i_in.baud_rate[TOPW-1:0];
                        n_state = S_QDIV;
                    end
                end
            end
            S_QDIV: begin
                if (s_done) begin
                    if (s_rem == '0) begin
                        // Exact divisor: fraction only appears while halving.
                        n_div    = s_quo_lo - 1'b1;
                        n_weight = WGT_W'(FRAC_FIRST);
                        n_exact  = 1'b1;
                        n_state  = S_SHIFT;
                    end else begin
                        n_exact = 1'b0;
                        s_start = 1'b1;
                        n_state = S_GDIV;
                    end
                end
            end
            S_GDIV: begin
                if (s_done) begin
                    n_good  = s_quo_lo;
                    s_start = 1'b1;
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                if (s_done) begin
                    n_div   = s_quo_lo - 1'b1;
                    s_start = 1'b1;
                    s_num   = {r_rate, FRAC_SHIFT'(0)};
                    s_den   = r_good;
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                if (s_done) begin
                    n_frac  = s_quo[FRAC_W-1:0];
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // One halving step per cycle until the divider fits.
                if (s_div_big) begin
                    n_div = r_div >> 1;
                    if (r_exact) begin
                        n_frac   = FRAC_W'(r_weight);
                        n_weight = r_weight >> 1;
                    end else begin
                        n_frac = r_frac >> 1;
                    end
                end else begin
                    s_start = 1'b1;
                    s_den   = r_div + 1'b1;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                if (s_done) begin
                    n_act   = s_quo_lo;
                    n_state = (r_frac != '0) ? S_MUL : S_OUT;
                end
            end
            S_MUL: begin
                n_prod  = r_act * r_frac;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_act   = r_prod[TOPW+FRAC_SHIFT-1:FRAC_SHIFT];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rate   <= n_rate;
        r_good   <= n_good;
        r_div    <= n_div;
        r_frac   <= n_frac;
        r_weight <= n_weight;
        r_exact  <= n_exact;
        r_act    <= n_act;
        r_prod   <= n_prod;
        r_inval  <= n_inval;
    end

    // Channel outputs come straight from registers.
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.divider_value  = DIV_W'(r_div);
    assign o_out.fraction_value = r_frac;
    assign o_out.actual_rate    = ACTUAL_W'(r_act);
    assign o_out.rate_invalid   = r_inval;

    // The block never takes a new word while a result word is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("request taken while a result is pending");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |-> (r_state == S_QDIV || r_state == S_GDIV ||
                    r_state == S_DDIV || r_state == S_FDIV || r_state == S_RDIV))
        else $error("divider finished outside a wait state");

    // A zero request gives an all-zero result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rate_invalid) |->
            (o_out.divider_value == '0 && o_out.fraction_value == '0 &&
             o_out.actual_rate == '0))
        else $error("invalid rate with nonzero result");

    // The divider has been brought within range before it is reported.
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(r_div) <= 32'(DIVIDER_MAX)))
        else $error("divider above its maximum");

    // The fraction never exceeds one whole.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_frac <= FRAC_W'(1 << FRAC_SHIFT)))
        else $error("fraction above 512");

endmodule
